[sv/uero_pkg.sv]
// shared types and constants for the ultrasonic echo ranger
package uero_pkg;

    localparam int SENSOR_COUNT_DEF = 4;

    localparam int WIDTH_W   = 16;
    localparam int ACTIVE_W  = 3;
    localparam int PERIOD_W  = 8;
    localparam int SEL_W     = 2;
    localparam int DIST_W    = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_SENSORS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_NEAR_WIDTH     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FAR_WIDTH      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_PERIOD = 2'd3;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 3'd2;
    localparam logic [WIDTH_W-1:0]  NEAR_RST   = 16'd116;
    localparam logic [WIDTH_W-1:0]  FAR_RST    = 16'd5800;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd25;

    // floor(w / 58) == (w * ceil(2^22 / 58)) >> 22 for every 16-bit w
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP_58 = 17'd72316;
    localparam int PROD_W = WIDTH_W + RECIP_W;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic               edge_en;
        logic               rise;
        logic [WIDTH_W-1:0] stamp;
        logic               scan;
        logic [WIDTH_W-1:0] near_width;
        logic [WIDTH_W-1:0] far_width;
    } cell_ctl_t;

endpackage

[sv/uero_cell.sv]
// one sensor cell: echo stamp, pulse width, and a link of the obstacle and width chains
module uero_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  uero_pkg::cell_ctl_t      ctl,
    input  logic                     sel,
    input  logic                     active,
    input  logic                     hit_in,
    output logic                     hit_out,
    input  logic [uero_pkg::WIDTH_W-1:0] width_in,
    output logic [uero_pkg::WIDTH_W-1:0] width_out
);
    import uero_pkg::*;

    logic [WIDTH_W-1:0] rise_reg;
    logic [WIDTH_W-1:0] pulse_reg;
    logic               hit_reg;
    logic               hit_next;
    logic               in_range;

    assign in_range = active && (pulse_reg > ctl.near_width) && (pulse_reg <= ctl.far_width);

    // hit spreads one cell per cycle while the scan runs
    assign hit_next = ctl.scan ? (hit_in | in_range) : 1'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rise_reg  <= '0;
            pulse_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            hit_reg <= hit_next;
            if (ctl.edge_en && sel) begin
                if (ctl.rise) begin
                    rise_reg <= ctl.stamp;
                end else begin
                    pulse_reg <= ctl.stamp - rise_reg;
                end
            end
        end
    end

    assign hit_out   = hit_reg;
    assign width_out = sel ? pulse_reg : width_in;

endmodule

[sv/ultrasonic_echo_ranger_obstacle_core.sv]
// top level of the multi-sensor ultrasonic echo ranger
// One item at a time. An echo edge passes through the execute and output states, and its result
// is registered in the output state; a falling edge adds a registered multiply by the reciprocal
// of 58 in a divide state between the two. A millisecond tick takes the same path as a rising edge,
// or adds a scan state and a blocked state when the period expires, since the obstacle check walks
// the row of sensor cells one cell per cycle. A new item is accepted once the result has moved into
// the output register, which may still be waiting on m_tready. Edges from sensors at or above the
// effective active count are ignored and yield a result carrying only the blocked flag.
module ultrasonic_echo_ranger_obstacle_core #(
    parameter int SENSOR_COUNT = uero_pkg::SENSOR_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sensor [1:0], level [2], timestamp [18:3]
    input  logic [uero_pkg::S_TDATA_W-1:0]    s_tdata,
    // op
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // trigger_fire [0], trigger_sensor [2:1], blocked [3], distance_valid [4],
    // distance_sensor [6:5], distance_cm [17:7]
    output logic [uero_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [uero_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [uero_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import uero_pkg::*;

    localparam int CNT_W  = $clog2(SENSOR_COUNT + 1);
    localparam int IDX_W  = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int SCAN_W = IDX_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_BLK  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]          state_reg, state_next;

    logic [ACTIVE_W-1:0] active_reg;
    logic [WIDTH_W-1:0]  near_reg;
    logic [WIDTH_W-1:0]  far_reg;
    logic [PERIOD_W-1:0] period_reg;

    logic                op_reg;
    logic [SEL_W-1:0]    sensor_reg;
    logic                level_reg;
    logic [WIDTH_W-1:0]  stamp_reg;

    logic [PERIOD_W-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic [IDX_W-1:0]    next_trig_reg, next_trig_next;
    logic                blocked_reg, blocked_next;
    logic [SCAN_W-1:0]   scan_cnt_reg, scan_cnt_next;

    logic                fire_reg, fire_next;
    logic [IDX_W-1:0]    fire_idx_reg, fire_idx_next;
    logic                dvalid_reg, dvalid_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [CNT_W-1:0]    live_n;
    logic                sensor_ok;
    logic [IDX_W-1:0]    rr_idx;
    logic [IDX_W-1:0]    rr_inc;
    logic                period_hit;

    cell_ctl_t           cell_ctl;
    logic [SENSOR_COUNT-1:0] edge_sel;
    logic [SENSOR_COUNT-1:0] cell_active;
    logic                hit_chain [SENSOR_COUNT+1];
    logic [WIDTH_W-1:0]  width_chain [SENSOR_COUNT+1];

    // effective sensor count: zero means one, above the cell count clamps
    always_comb begin
        if (active_reg == '0) begin
            live_n = CNT_W'(1);
        end else if (32'(active_reg) > SENSOR_COUNT) begin
            live_n = CNT_W'(SENSOR_COUNT);
        end else begin
            live_n = CNT_W'(active_reg);
        end
    end

    assign sensor_ok = 32'(sensor_reg) < 32'(live_n);

    assign cell_ctl.edge_en    = (state_reg == ST_EXEC) && !op_reg;
    assign cell_ctl.rise       = level_reg;
    assign cell_ctl.stamp      = stamp_reg;
    assign cell_ctl.scan       = (state_reg == ST_SCAN);
    assign cell_ctl.near_width = near_reg;
    assign cell_ctl.far_width  = far_reg;

    assign hit_chain[0]   = 1'b0;
    assign width_chain[0] = '0;

    for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_cell
        assign edge_sel[i]    = sensor_ok && (32'(sensor_reg) == i);
        assign cell_active[i] = i < 32'(live_n);
        uero_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (cell_ctl),
            .sel       (edge_sel[i]),
            .active    (cell_active[i]),
            .hit_in    (hit_chain[i]),
            .hit_out   (hit_chain[i+1]),
            .width_in  (width_chain[i]),
            .width_out (width_chain[i+1])
        );
    end

    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + PERIOD_W'(1) : elapsed_reg;
    assign period_hit  = elapsed_inc >= period_reg;
    // stale index after a count change restarts at sensor zero
    assign rr_idx      = (32'(next_trig_reg) >= 32'(live_n)) ? '0 : next_trig_reg;
    assign rr_inc      = (32'(rr_idx) + 1 >= 32'(live_n)) ? '0 : rr_idx + IDX_W'(1);

    always_comb begin
        state_next     = state_reg;
        elapsed_next   = elapsed_reg;
        next_trig_next = next_trig_reg;
        blocked_next   = blocked_reg;
        scan_cnt_next  = scan_cnt_reg;
        fire_next      = fire_reg;
        fire_idx_next  = fire_idx_reg;
        dvalid_next    = dvalid_reg;
        prod_next      = prod_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                fire_next     = 1'b0;
                fire_idx_next = '0;
                dvalid_next   = 1'b0;
                prod_next     = '0;
                state_next    = ST_OUT;
                if (!op_reg) begin
                    if (sensor_ok && !level_reg) begin
                        dvalid_next = 1'b1;
                        state_next  = ST_DIV;
                    end
                end else if (period_hit) begin
                    elapsed_next   = '0;
                    fire_next      = 1'b1;
                    fire_idx_next  = rr_idx;
                    next_trig_next = rr_inc;
                    scan_cnt_next  = '0;
                    state_next     = ST_SCAN;
                end else begin
                    elapsed_next = elapsed_inc;
                end
            end
            ST_DIV: begin
                prod_next  = PROD_W'(width_chain[SENSOR_COUNT]) * PROD_W'(RECIP_58);
                state_next = ST_OUT;
            end
            ST_SCAN: begin
                scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                if (scan_cnt_reg == SCAN_W'(SENSOR_COUNT - 1)) begin
                    state_next = ST_BLK;
                end
            end
            ST_BLK: begin
                blocked_next = hit_chain[SENSOR_COUNT];
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[0]    = fire_reg;
                    m_tdata_next[2:1]  = SEL_W'(fire_idx_reg);
                    m_tdata_next[3]    = blocked_reg;
                    m_tdata_next[4]    = dvalid_reg;
                    m_tdata_next[6:5]  = dvalid_reg ? sensor_reg : '0;
                    m_tdata_next[17:7] = prod_reg[RECIP_SHIFT +: DIST_W];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= ACTIVE_RST;
            near_reg      <= NEAR_RST;
            far_reg       <= FAR_RST;
            period_reg    <= PERIOD_RST;
            elapsed_reg   <= '0;
            next_trig_reg <= '0;
            blocked_reg   <= 1'b0;
            scan_cnt_reg  <= '0;
            fire_reg      <= 1'b0;
            dvalid_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            next_trig_reg <= next_trig_next;
            blocked_reg   <= blocked_next;
            scan_cnt_reg  <= scan_cnt_next;
            fire_reg      <= fire_next;
            dvalid_reg    <= dvalid_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_ACTIVE_SENSORS: active_reg <= cfg_wdata[ACTIVE_W-1:0];
                    REG_NEAR_WIDTH:     near_reg   <= cfg_wdata[WIDTH_W-1:0];
                    REG_FAR_WIDTH:      far_reg    <= cfg_wdata[WIDTH_W-1:0];
                    REG_TRIGGER_PERIOD: period_reg <= cfg_wdata[PERIOD_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        fire_idx_reg <= fire_idx_next;
        prod_reg     <= prod_next;
        m_tdata_reg  <= m_tdata_next;
        if (s_tvalid && s_tready) begin
            op_reg     <= s_tuser;
            sensor_reg <= s_tdata[1:0];
            level_reg  <= s_tdata[2];
            stamp_reg  <= s_tdata[18:3];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_out_from_final: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result appeared outside the output state");

    a_fire_xor_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(m_tdata_reg[0] && m_tdata_reg[4]))
        else $error("trigger and distance in one result");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (32'(scan_cnt_reg) < SENSOR_COUNT))
        else $error("scan ran past the last cell");

    a_fire_resets_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && scan_cnt_reg == '0) |-> (elapsed_reg == '0 && fire_reg))
        else $error("period expiry did not clear the counter");
`endif

endmodule
